// File: src/sfc_pkg.sv
package sfc_pkg;

    // Most planes the block can hold.
    localparam int PLANE_MAX = 6;

    // Field widths of one sphere.
    localparam int COORD_W  = 28;
    localparam int RADIUS_W = 27;

    // Plane packing widths.
    localparam int NORM_W   = 12;
    localparam int OFFSET_W = 28;
    localparam int MARGIN_W = 12;

    // Register port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Datapath widths.
    // A normal component times a coordinate.
    localparam int PROD_W  = NORM_W + COORD_W;
    // Radius plus margin before scaling to Q.22.
    localparam int LIM_W   = RADIUS_W + 1;
    // Scale from Q.12 to Q.22.
    localparam int SCALE_W = 10;
    // Three products plus scaled offset plus scaled limit, with sign.
    localparam int SUM_W   = PROD_W + 2;

    // Register index of the margin register.
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = CFG_IDX_W'(6);

    // One plane as it is packed in its register.
    typedef struct packed {
        logic signed [NORM_W-1:0]   nx;
        logic signed [NORM_W-1:0]   ny;
        logic signed [NORM_W-1:0]   nz;
        logic signed [OFFSET_W-1:0] d;
    } plane_t;

endpackage

// File: src/sfc_cfg_regs.sv
module sfc_cfg_regs #(
    parameter int PLANE_COUNT = sfc_pkg::PLANE_MAX
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]        cfg_data,
    output sfc_pkg::plane_t [PLANE_COUNT-1:0]     planes,
    output logic [sfc_pkg::MARGIN_W-1:0]          margin
);

    import sfc_pkg::*;

    plane_t [PLANE_COUNT-1:0] plane_reg;
    logic [MARGIN_W-1:0]      margin_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Plane registers; planes past the configured count are not stored.
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg[p] <= '0;
            end
            else if (cfg_valid && cfg_index == CFG_IDX_W'(p))
            begin
                plane_reg[p] <= plane_t'(cfg_data);
            end
        end
    end

    // Margin register keeps the low bits of the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= '0;
        end
        else if (cfg_valid && cfg_index == REG_MARGIN)
        begin
            margin_reg <= cfg_data[MARGIN_W-1:0];
        end
    end

    assign planes = plane_reg;
    assign margin = margin_reg;

endmodule

// File: src/sfc_pipe.sv
module sfc_pipe #(
    parameter int PLANE_COUNT = sfc_pkg::PLANE_MAX
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sfc_pkg::plane_t [PLANE_COUNT-1:0]     planes,
    input  logic [sfc_pkg::MARGIN_W-1:0]          margin,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic signed [sfc_pkg::COORD_W-1:0]    center_x,
    input  logic signed [sfc_pkg::COORD_W-1:0]    center_y,
    input  logic signed [sfc_pkg::COORD_W-1:0]    center_z,
    input  logic [sfc_pkg::RADIUS_W-1:0]          radius,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic                                  visible
);

    import sfc_pkg::*;

    localparam int PAD_W = SUM_W - (OFFSET_W + SCALE_W);
    localparam int LPAD_W = SUM_W - (LIM_W + SCALE_W);

    // Stage valid bits and their next values.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;

    // Per-stage advance: a stage takes new data when it is empty or drains.
    logic adv1, adv2, adv3;

    // Stage 1: products and unscaled limit.
    logic signed [PROD_W-1:0] px_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0] py_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0] pz_reg [PLANE_COUNT];
    logic [LIM_W-1:0]         lim_reg;

    // Stage 2: two partial sums per plane.
    logic signed [SUM_W-1:0] part_a_reg [PLANE_COUNT];
    logic signed [SUM_W-1:0] part_b_reg [PLANE_COUNT];

    // Stage 3: result.
    logic                    visible_reg;
    logic [PLANE_COUNT-1:0]  cull;

    assign adv3 = !s3_valid_reg || !result_stall;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign item_stall = !adv1;

    // Valid bits move with the data.
    always_comb
    begin
        s1_valid_next = adv1 ? item_valid   : s1_valid_reg;
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = adv3 ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Stage 1: the limit is radius plus margin, still in Q.12.
    always_ff @(posedge clk)
    begin
        if (adv1 && item_valid)
        begin
            lim_reg <= LIM_W'(radius) + LIM_W'(margin);
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        logic signed [SUM_W-1:0] d_ext;
        logic signed [SUM_W-1:0] lim_ext;
        logic signed [SUM_W-1:0] total;

        // Stage 1: one multiply per normal component.
        always_ff @(posedge clk)
        begin
            if (adv1 && item_valid)
            begin
                px_reg[p] <= PROD_W'(planes[p].nx) * PROD_W'(center_x);
                py_reg[p] <= PROD_W'(planes[p].ny) * PROD_W'(center_y);
                pz_reg[p] <= PROD_W'(planes[p].nz) * PROD_W'(center_z);
            end
        end

        // Offset and limit brought to Q.22.
        assign d_ext   = {{PAD_W{planes[p].d[OFFSET_W-1]}}, planes[p].d, {SCALE_W{1'b0}}};
        assign lim_ext = {{LPAD_W{1'b0}}, lim_reg, {SCALE_W{1'b0}}};

        // Stage 2: split the five-term sum into two partial sums.
        always_ff @(posedge clk)
        begin
            if (adv2 && s1_valid_reg)
            begin
                part_a_reg[p] <= SUM_W'(px_reg[p]) + SUM_W'(py_reg[p]);
                part_b_reg[p] <= SUM_W'(pz_reg[p]) + d_ext + lim_ext;
            end
        end

        // Stage 3: the plane culls when dist + limit is negative.
        assign total   = part_a_reg[p] + part_b_reg[p];
        assign cull[p] = total[SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid_reg)
        begin
            visible_reg <= ~|cull;
        end
    end

    assign result_valid = s3_valid_reg;
    assign visible      = visible_reg;

`ifndef SYNTHESIS
    // The input is held back only when every stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("input stalled with an empty stage");

    // An accepted beat lands in the first stage.
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> s1_valid_reg)
        else $error("accepted beat lost at stage 1");

    // A blocked middle stage keeps its beat.
    a_hold_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !adv3) |=> s2_valid_reg)
        else $error("stage 2 beat dropped under stall");

    // A beat leaving stage 2 reaches the output register.
    a_move_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && adv3) |=> s3_valid_reg)
        else $error("stage 2 beat lost on the way out");
`endif

endmodule

// File: src/sphere_frustum_cull.sv
// Sphere versus view frustum cull test.
// Input channel: one bounding sphere per beat (center_x, center_y, center_z
// in signed Q16.12, radius in unsigned Q15.12) on item_valid / item_stall.
// A beat is taken on a clock edge with item_valid high and item_stall low.
// Output channel: one visible flag per sphere on result_valid / result_stall;
// visible is 0 when some plane puts the whole sphere, grown by the margin,
// outside the frustum.
// Planes and the margin are loaded on the cfg port (index 0..5 planes in the
// order left, right, bottom, top, near, far; index 6 margin); cfg_ready is
// always high and writes belong in idle periods.
// An accepted beat reaches result_valid through one stage of 12 x 28
// multipliers, one stage of partial sums and one stage for the final add,
// the sign test and the output register.
// Throughput is one sphere per cycle while result_stall is low. Each stage has its own valid bit, so
// while result_stall is high the stages behind the output still fill, and
// item_stall rises only once all three hold a beat; nothing is dropped.
// Reset clears all planes and the margin to zero and empties the pipeline.
module sphere_frustum_cull #(
    parameter int PLANE_COUNT = sfc_pkg::PLANE_MAX
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic signed [sfc_pkg::COORD_W-1:0]    center_x,
    input  logic signed [sfc_pkg::COORD_W-1:0]    center_y,
    input  logic signed [sfc_pkg::COORD_W-1:0]    center_z,
    input  logic [sfc_pkg::RADIUS_W-1:0]          radius,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic                                  visible
);

    import sfc_pkg::*;

    plane_t [PLANE_COUNT-1:0] planes;
    logic [MARGIN_W-1:0]      margin;

    // Plane and margin registers.
    sfc_cfg_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes),
        .margin    (margin)
    );

    // Three-stage distance and compare pipeline.
    sfc_pipe #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .planes       (planes),
        .margin       (margin),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .radius       (radius),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .visible      (visible)
    );

endmodule
